// File: src/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the script token lexer
// Token kinds, scan modes, character classes and the beat carried between
// the front scanner and the back result serialiser.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int PosW   = 16;
  localparam int KwChars = 5;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  localparam logic [5:0] KIND_LPAREN = 6'd0;
  localparam logic [5:0] KIND_RPAREN = 6'd1;
  localparam logic [5:0] KIND_LBRACE = 6'd2;
  localparam logic [5:0] KIND_RBRACE = 6'd3;
  localparam logic [5:0] KIND_COMMA  = 6'd4;
  localparam logic [5:0] KIND_DOT    = 6'd5;
  localparam logic [5:0] KIND_MINUS  = 6'd6;
  localparam logic [5:0] KIND_PLUS   = 6'd7;
  localparam logic [5:0] KIND_SEMI   = 6'd8;
  localparam logic [5:0] KIND_SLASH  = 6'd9;
  localparam logic [5:0] KIND_STAR   = 6'd10;
  localparam logic [5:0] KIND_BANG   = 6'd11;
  localparam logic [5:0] KIND_IDENT  = 6'd19;
  localparam logic [5:0] KIND_STRING = 6'd20;
  localparam logic [5:0] KIND_NUMBER = 6'd21;
  localparam logic [5:0] KIND_AND    = 6'd22;
  localparam logic [5:0] KIND_END    = 6'd35;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_CHAR  = 2'd1;
  localparam logic [1:0] ERR_STRING = 2'd2;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_SLASH, MODE_OP, MODE_STRING, MODE_INT,
    MODE_DOT, MODE_FRAC, MODE_WORD, MODE_COMMENT, MODE_DISCARD
  } mode_t;

  typedef struct packed {
    logic [5:0]      kind;
    logic [PosW-1:0] start;
    logic [PosW-1:0] len;
    logic [PosW-1:0] line;
    logic [PosW-1:0] col;
    logic [1:0]      err;
  } tok_t;

  // up to four results per source byte
  typedef struct packed {
    logic [2:0] cnt;
    tok_t [3:0] tok;
  } grp_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_wstart(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [PosW-1:0] sat_inc(input logic [PosW-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [PosW-1:0] sat_dec(input logic [PosW-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  // keyword lookup over a zero-padded word buffer
  function automatic logic [5:0] kw_kind(input logic [KwChars*8-1:0] w,
                                         input logic [PosW-1:0] len);
    logic [5:0] k;
    k = KIND_IDENT;
    if (len <= PosW'(KwChars)) begin
      case (w[39:0])
        {"and", 16'h0}:   k = 6'd22;
        "class":          k = 6'd23;
        {"else", 8'h0}:   k = 6'd24;
        "false":          k = 6'd25;
        {"fun", 16'h0}:   k = 6'd26;
        {"for", 16'h0}:   k = 6'd27;
        {"if", 24'h0}:    k = 6'd28;
        {"nil", 16'h0}:   k = 6'd29;
        {"or", 24'h0}:    k = 6'd30;
        "super":          k = 6'd31;
        {"true", 8'h0}:   k = 6'd32;
        {"var", 16'h0}:   k = 6'd33;
        "while":          k = 6'd34;
        default:          k = KIND_IDENT;
      endcase
    end
    return k;
  endfunction

endpackage

// File: src/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front: byte scanner
// Classifies each source byte, updates the scan state and counters and
// produces the group of up to four tokens that the byte completes.
// ----------------------------------------------------------------------------
module stl_front import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_final_byte,
  output logic       grp_valid,
  input  logic       grp_full,
  output grp_t       grp
);

  mode_t           mode_r, mode_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [PosW-1:0] ts_r, ts_nxt, tl_r, tl_nxt, tc_r, tc_nxt;
  logic [PosW-1:0] bp_r, bp_nxt, ln_r, ln_nxt, cc_r, cc_nxt;
  logic [39:0]     wb_r, wb_nxt;

  assign in_stall  = grp_full;
  assign grp_valid = in_valid && !grp_full;

  always_comb begin
    logic [7:0] c;
    logic       go;
    logic [2:0] n;
    tok_t [3:0] t;
    logic [PosW-1:0] wi;
    c = in_char_byte;
    n = '0;
    t = '0;
    go = 1'b0;
    wi = '0;
    mode_nxt = mode_r; op_nxt = op_r;
    ts_nxt = ts_r; tl_nxt = tl_r; tc_nxt = tc_r;
    bp_nxt = bp_r; ln_nxt = ln_r; cc_nxt = cc_r; wb_nxt = wb_r;

    case (mode_r)
      MODE_DISCARD: begin
        bp_nxt = sat_inc(bp_nxt); cc_nxt = sat_inc(cc_nxt);
        if (c == 8'h0a) begin ln_nxt = sat_inc(ln_nxt); cc_nxt = '0; end
      end
      MODE_SLASH:
        if (c == "/") begin
          bp_nxt = sat_inc(bp_nxt); cc_nxt = sat_inc(cc_nxt); mode_nxt = MODE_COMMENT;
        end else begin
          t[n] = '{KIND_SLASH, ts_r, bp_r - ts_r, tl_r, tc_r, ERR_NONE}; n = n + 1'b1;
          go = 1'b1;
        end
      MODE_OP:
        if (c == "=") begin
          bp_nxt = sat_inc(bp_nxt); cc_nxt = sat_inc(cc_nxt);
          t[n] = '{6'd12 + {3'd0, op_r, 1'b0}, ts_r, bp_nxt - ts_r, tl_r, tc_r, ERR_NONE};
          n = n + 1'b1; mode_nxt = MODE_IDLE;
        end else begin
          t[n] = '{6'd11 + {3'd0, op_r, 1'b0}, ts_r, bp_r - ts_r, tl_r, tc_r, ERR_NONE};
          n = n + 1'b1; go = 1'b1;
        end
      MODE_STRING:
        if (c == "\"") begin
          bp_nxt = sat_inc(bp_nxt); cc_nxt = sat_inc(cc_nxt);
          t[n] = '{KIND_STRING, ts_r, bp_nxt - ts_r, tl_r, tc_r, ERR_NONE};
          n = n + 1'b1; mode_nxt = MODE_IDLE;
        end else begin
          if (c == 8'h0a) begin ln_nxt = sat_inc(ln_nxt); cc_nxt = '0; end
          bp_nxt = sat_inc(bp_nxt); cc_nxt = sat_inc(cc_nxt);
        end
      MODE_INT:
        if (is_digit(c)) begin
          bp_nxt = sat_inc(bp_nxt); cc_nxt = sat_inc(cc_nxt);
        end else if (c == ".") begin
          bp_nxt = sat_inc(bp_nxt); cc_nxt = sat_inc(cc_nxt); mode_nxt = MODE_DOT;
        end else begin
          t[n] = '{KIND_NUMBER, ts_r, bp_r - ts_r, tl_r, tc_r, ERR_NONE};
          n = n + 1'b1; go = 1'b1;
        end
      MODE_DOT:
        if (is_digit(c)) begin
          bp_nxt = sat_inc(bp_nxt); cc_nxt = sat_inc(cc_nxt); mode_nxt = MODE_FRAC;
        end else begin
          t[0] = '{KIND_NUMBER, ts_r, sat_dec(bp_r - ts_r), tl_r, tc_r, ERR_NONE};
          t[1] = '{KIND_DOT, sat_dec(bp_r), PosW'(1), ln_r, sat_dec(cc_r), ERR_NONE};
          n = 3'd2; go = 1'b1;
        end
      MODE_FRAC:
        if (is_digit(c)) begin
          bp_nxt = sat_inc(bp_nxt); cc_nxt = sat_inc(cc_nxt);
        end else begin
          t[n] = '{KIND_NUMBER, ts_r, bp_r - ts_r, tl_r, tc_r, ERR_NONE};
          n = n + 1'b1; go = 1'b1;
        end
      MODE_WORD:
        if (is_wstart(c) || is_digit(c)) begin
          wi = bp_r - ts_r;
          if (wi < PosW'(KwChars)) wb_nxt[39 - 8*wi[2:0] -: 8] = c;
          bp_nxt = sat_inc(bp_nxt); cc_nxt = sat_inc(cc_nxt);
        end else begin
          t[n] = '{kw_kind(wb_r, bp_r - ts_r), ts_r, bp_r - ts_r, tl_r, tc_r, ERR_NONE};
          n = n + 1'b1; go = 1'b1;
        end
      MODE_COMMENT:
        if (c == 8'h0a) go = 1'b1;
        else begin bp_nxt = sat_inc(bp_nxt); cc_nxt = sat_inc(cc_nxt); end
      default: go = 1'b1;
    endcase

    if (go) begin
      mode_nxt = MODE_IDLE;
      ts_nxt = bp_r; tl_nxt = ln_r; tc_nxt = cc_r;
      bp_nxt = sat_inc(bp_r); cc_nxt = sat_inc(cc_r);
      case (c)
        8'h0a: begin ln_nxt = sat_inc(ln_r); cc_nxt = '0; end
        " ", 8'h0d, 8'h09: ;
        "(", ")", "{", "}", ",", ".", "-", "+", ";", "*": begin
          case (c)
            "(": t[n].kind = KIND_LPAREN;
            ")": t[n].kind = KIND_RPAREN;
            "{": t[n].kind = KIND_LBRACE;
            "}": t[n].kind = KIND_RBRACE;
            ",": t[n].kind = KIND_COMMA;
            ".": t[n].kind = KIND_DOT;
            "-": t[n].kind = KIND_MINUS;
            "+": t[n].kind = KIND_PLUS;
            ";": t[n].kind = KIND_SEMI;
            default: t[n].kind = KIND_STAR;
          endcase
          t[n].start = bp_r; t[n].len = bp_nxt - bp_r;
          t[n].line = ln_r; t[n].col = cc_r; t[n].err = ERR_NONE;
          n = n + 1'b1;
        end
        "/": mode_nxt = MODE_SLASH;
        "!": begin mode_nxt = MODE_OP; op_nxt = 2'd0; end
        "=": begin mode_nxt = MODE_OP; op_nxt = 2'd1; end
        ">": begin mode_nxt = MODE_OP; op_nxt = 2'd2; end
        "<": begin mode_nxt = MODE_OP; op_nxt = 2'd3; end
        "\"": mode_nxt = MODE_STRING;
        default:
          if (is_digit(c)) mode_nxt = MODE_INT;
          else if (is_wstart(c)) begin
            wb_nxt = {c, 32'h0}; mode_nxt = MODE_WORD;
          end else begin
            t[n] = '{KIND_LPAREN, bp_r, PosW'(1), ln_r, cc_r, ERR_CHAR};
            n = n + 1'b1; mode_nxt = MODE_DISCARD;
          end
      endcase
    end

    if (in_final_byte) begin
      case (mode_nxt)
        MODE_SLASH: begin
          t[n] = '{KIND_SLASH, ts_nxt, bp_nxt - ts_nxt, tl_nxt, tc_nxt, ERR_NONE};
          n = n + 1'b1;
        end
        MODE_OP: begin
          t[n] = '{KIND_BANG + {3'd0, op_nxt, 1'b0}, ts_nxt, bp_nxt - ts_nxt, tl_nxt,
                   tc_nxt, ERR_NONE};
          n = n + 1'b1;
        end
        MODE_STRING: begin
          t[n] = '{KIND_LPAREN, ts_nxt, bp_nxt - ts_nxt, tl_nxt, tc_nxt, ERR_STRING};
          n = n + 1'b1;
        end
        MODE_INT, MODE_FRAC: begin
          t[n] = '{KIND_NUMBER, ts_nxt, bp_nxt - ts_nxt, tl_nxt, tc_nxt, ERR_NONE};
          n = n + 1'b1;
        end
        MODE_DOT: begin
          t[n] = '{KIND_NUMBER, ts_nxt, sat_dec(bp_nxt - ts_nxt), tl_nxt, tc_nxt,
                   ERR_NONE};
          t[n+1] = '{KIND_DOT, sat_dec(bp_nxt), PosW'(1), ln_nxt, sat_dec(cc_nxt),
                     ERR_NONE};
          n = n + 3'd2;
        end
        MODE_WORD: begin
          t[n] = '{kw_kind(wb_nxt, bp_nxt - ts_nxt), ts_nxt, bp_nxt - ts_nxt, tl_nxt,
                   tc_nxt, ERR_NONE};
          n = n + 1'b1;
        end
        default: ;
      endcase
      t[n] = '{KIND_END, bp_nxt, '0, ln_nxt, cc_nxt, ERR_NONE};
      n = n + 1'b1;
      mode_nxt = MODE_IDLE; op_nxt = '0;
      ts_nxt = '0; tl_nxt = PosW'(1); tc_nxt = '0;
      bp_nxt = '0; ln_nxt = PosW'(1); cc_nxt = '0; wb_nxt = '0;
    end
    grp.cnt = n;
    grp.tok = t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE; op_r <= '0;
      ts_r <= '0; tl_r <= PosW'(1); tc_r <= '0;
      bp_r <= '0; ln_r <= PosW'(1); cc_r <= '0; wb_r <= '0;
    end else if (grp_valid) begin
      mode_r <= mode_nxt; op_r <= op_nxt;
      ts_r <= ts_nxt; tl_r <= tl_nxt; tc_r <= tc_nxt;
      bp_r <= bp_nxt; ln_r <= ln_nxt; cc_r <= cc_nxt; wb_r <= wb_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    grp_valid && in_final_byte |=> mode_r == MODE_IDLE && bp_r == '0)
    else $error("state not cleared after final byte");
  assert property (@(posedge clk) disable iff (!rst_n)
    grp_valid && in_final_byte |-> grp.cnt != 3'd0)
    else $error("final byte without end token");
  assert property (@(posedge clk) disable iff (!rst_n)
    grp_valid |-> grp.cnt <= 3'd4)
    else $error("too many tokens for one byte");

endmodule

// File: src/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back: token queue and serialiser
// Holds token groups in a short queue and sends their tokens one beat at a
// time, marking the last token of each group.
// ----------------------------------------------------------------------------
module stl_back import stl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            grp_valid,
  output logic            grp_full,
  input  grp_t            grp,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [5:0]      out_token_kind,
  output logic [PosW-1:0] out_start_offset,
  output logic [PosW-1:0] out_lexeme_length,
  output logic [PosW-1:0] out_start_line,
  output logic [PosW-1:0] out_start_column,
  output logic [1:0]      out_error_code,
  output logic            out_end_of_run
);

  grp_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] fill_r;
  logic [1:0] sel_r;
  logic       push, pop, head_ok, last;
  tok_t       cur;

  assign head_ok = fill_r != 3'd0;
  assign push = grp_valid && grp.cnt != 3'd0;
  assign grp_full = fill_r == 3'd4;
  assign cur = q_r[rp_r].tok[sel_r];
  assign last = {1'b0, sel_r} + 3'd1 == q_r[rp_r].cnt;
  assign out_valid = head_ok;
  assign pop = head_ok && !out_stall && last;

  assign out_token_kind    = cur.kind;
  assign out_start_offset  = cur.start;
  assign out_lexeme_length = cur.len;
  assign out_start_line    = cur.line;
  assign out_start_column  = cur.col;
  assign out_error_code    = cur.err;
  assign out_end_of_run    = last;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; fill_r <= '0; sel_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      fill_r <= fill_r + {2'd0, push} - {2'd0, pop};
      if (head_ok && !out_stall) sel_r <= last ? 2'd0 : sel_r + 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 3'd4) else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    head_ok |-> q_r[rp_r].cnt != 3'd0) else $error("empty group queued");
  assert property (@(posedge clk) disable iff (!rst_n)
    !head_ok |-> sel_r == 2'd0) else $error("token select not cleared");

endmodule

// File: src/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer: streaming lexer for a small scripting language
// Takes one source byte per beat and emits tokens with position data.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while in_stall is low. Each byte yields zero
// to four tokens; the output side holds them as a group in a four-deep queue and
// sends one token per cycle while out_stall is low, the first token of a byte
// leaving from that registered queue. A byte with no token puts no group in the
// queue, and input stalls only while the queue holds four groups.
module script_token_lexer import stl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_start_offset,
  output logic [15:0] out_lexeme_length,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic [1:0]  out_error_code,
  output logic        out_end_of_run
);

  logic grp_valid, grp_full;
  grp_t grp;

  stl_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_char_byte, .in_final_byte,
    .grp_valid, .grp_full, .grp
  );

  stl_back u_back (
    .clk, .rst_n, .grp_valid, .grp_full, .grp, .out_valid, .out_stall,
    .out_token_kind, .out_start_offset, .out_lexeme_length, .out_start_line,
    .out_start_column, .out_error_code, .out_end_of_run
  );

endmodule

// File: test/script_token_lexer_tb.sv
// ----------------------------------------------------------------------------
// script_token_lexer_tb: self-checking bench for the script token lexer
// Streams source texts byte by byte, predicts every token in a scanner model
// of its own and compares each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module script_token_lexer_tb;
  import stl_pkg::*;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic [1:0]  err;
    logic        last;
  } token_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_byte;
  logic        in_final_byte;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_token_kind;
  logic [15:0] out_start_offset;
  logic [15:0] out_lexeme_length;
  logic [15:0] out_start_line;
  logic [15:0] out_start_column;
  logic [1:0]  out_error_code;
  logic        out_end_of_run;

  script_token_lexer i_dut (.*);

  token_beat_t expected_tokens[$];
  int          fail_count;
  int          cycle_count;
  bit          calm_phase;

  // scanner model state
  mode_t       lex_mode;
  logic [1:0]  lex_op;
  logic [15:0] tok_start, tok_line, tok_col, pos, line_no, col_no;
  logic [39:0] word_buf;
  token_beat_t beat_grp[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic [15:0] inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] dec16(logic [15:0] v);
    return (v == 16'h0) ? v : v - 16'd1;
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_start_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] keyword_kind(logic [39:0] w, logic [15:0] n);
    if (n > 16'd5) return KIND_IDENT;
    case (w)
      {"and", 16'h0}: return KIND_AND;
      "class":        return 6'd23;
      {"else", 8'h0}: return 6'd24;
      "false":        return 6'd25;
      {"fun", 16'h0}: return 6'd26;
      {"for", 16'h0}: return 6'd27;
      {"if", 24'h0}:  return 6'd28;
      {"nil", 16'h0}: return 6'd29;
      {"or", 24'h0}:  return 6'd30;
      "super":        return 6'd31;
      {"true", 8'h0}: return 6'd32;
      {"var", 16'h0}: return 6'd33;
      "while":        return 6'd34;
      default:        return KIND_IDENT;
    endcase
  endfunction

  function automatic void lex_reset();
    lex_mode = MODE_IDLE;
    lex_op = 2'd0;
    tok_start = 16'd0;
    tok_line = 16'd1;
    tok_col = 16'd0;
    pos = 16'd0;
    line_no = 16'd1;
    col_no = 16'd0;
    word_buf = '0;
  endfunction

  function automatic void push_beat(logic [5:0] k, logic [15:0] s, logic [15:0] n,
                                    logic [15:0] ln, logic [15:0] cl, logic [1:0] e);
    token_beat_t b;
    b = '{k, s, n, ln, cl, e, 1'b0};
    if (beat_grp.size() < 4) beat_grp = {beat_grp, b};
  endfunction

  function automatic void push_token(logic [5:0] k);
    push_beat(k, tok_start, pos - tok_start, tok_line, tok_col, ERR_NONE);
  endfunction

  function automatic void push_number_dot();
    push_beat(KIND_NUMBER, tok_start, dec16(pos - tok_start), tok_line, tok_col, ERR_NONE);
    push_beat(KIND_DOT, dec16(pos), 16'd1, line_no, dec16(col_no), ERR_NONE);
  endfunction

  function automatic logic [5:0] single_op(logic [1:0] op);
    return KIND_BANG + 6'(2 * op);
  endfunction

  function automatic void take();
    pos = inc16(pos);
    col_no = inc16(col_no);
  endfunction

  function automatic void start_token(logic [7:0] c);
    lex_mode = MODE_IDLE;
    tok_start = pos;
    tok_line = line_no;
    tok_col = col_no;
    take();
    case (c)
      8'h0A: begin
        line_no = inc16(line_no);
        col_no = 16'd0;
      end
      " ", 8'h0D, 8'h09: ;
      "(": push_token(KIND_LPAREN);
      ")": push_token(KIND_RPAREN);
      "{": push_token(KIND_LBRACE);
      "}": push_token(KIND_RBRACE);
      ",": push_token(KIND_COMMA);
      ".": push_token(KIND_DOT);
      "-": push_token(KIND_MINUS);
      "+": push_token(KIND_PLUS);
      ";": push_token(KIND_SEMI);
      "*": push_token(KIND_STAR);
      "/": lex_mode = MODE_SLASH;
      "!": begin lex_mode = MODE_OP; lex_op = 2'd0; end
      "=": begin lex_mode = MODE_OP; lex_op = 2'd1; end
      ">": begin lex_mode = MODE_OP; lex_op = 2'd2; end
      "<": begin lex_mode = MODE_OP; lex_op = 2'd3; end
      "\"": lex_mode = MODE_STRING;
      default: begin
        if (digit_ch(c)) begin
          lex_mode = MODE_INT;
        end else if (word_start_ch(c)) begin
          word_buf = {c, 32'h0};
          lex_mode = MODE_WORD;
        end else begin
          push_beat(KIND_LPAREN, tok_start, 16'd1, tok_line, tok_col, ERR_CHAR);
          lex_mode = MODE_DISCARD;
        end
      end
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] c, logic fin);
    logic [15:0] idx;
    beat_grp.delete();
    case (lex_mode)
      MODE_DISCARD: begin
        take();
        if (c == 8'h0A) begin
          line_no = inc16(line_no);
          col_no = 16'd0;
        end
      end
      MODE_SLASH:
        if (c == "/") begin take(); lex_mode = MODE_COMMENT; end
        else begin push_token(KIND_SLASH); start_token(c); end
      MODE_OP:
        if (c == "=") begin
          take();
          push_token(single_op(lex_op) + 6'd1);
          lex_mode = MODE_IDLE;
        end else begin
          push_token(single_op(lex_op));
          start_token(c);
        end
      MODE_STRING:
        if (c == "\"") begin
          take();
          push_token(KIND_STRING);
          lex_mode = MODE_IDLE;
        end else begin
          if (c == 8'h0A) begin
            line_no = inc16(line_no);
            col_no = 16'd0;
          end
          take();
        end
      MODE_INT:
        if (digit_ch(c)) take();
        else if (c == ".") begin take(); lex_mode = MODE_DOT; end
        else begin push_token(KIND_NUMBER); start_token(c); end
      MODE_DOT:
        if (digit_ch(c)) begin take(); lex_mode = MODE_FRAC; end
        else begin push_number_dot(); start_token(c); end
      MODE_FRAC:
        if (digit_ch(c)) take();
        else begin push_token(KIND_NUMBER); start_token(c); end
      MODE_WORD:
        if (word_start_ch(c) || digit_ch(c)) begin
          idx = pos - tok_start;
          if (idx < 16'd5) word_buf[39 - 8 * idx -: 8] = c;
          take();
        end else begin
          push_token(keyword_kind(word_buf, pos - tok_start));
          start_token(c);
        end
      MODE_COMMENT:
        if (c == 8'h0A) start_token(c);
        else take();
      default: start_token(c);
    endcase
    if (fin) begin
      case (lex_mode)
        MODE_SLASH:  push_token(KIND_SLASH);
        MODE_OP:     push_token(single_op(lex_op));
        MODE_STRING: push_beat(KIND_LPAREN, tok_start, pos - tok_start, tok_line, tok_col,
                               ERR_STRING);
        MODE_INT, MODE_FRAC: push_token(KIND_NUMBER);
        MODE_DOT:    push_number_dot();
        MODE_WORD:   push_token(keyword_kind(word_buf, pos - tok_start));
        default: ;
      endcase
      push_beat(KIND_END, pos, 16'd0, line_no, col_no, ERR_NONE);
      lex_reset();
    end
    if (beat_grp.size() > 0) beat_grp[beat_grp.size() - 1].last = 1'b1;
    expected_tokens = {expected_tokens, beat_grp};
  endfunction

  task automatic send_byte(logic [7:0] c, logic fin);
    while (!calm_phase && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= c;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(c, fin);
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit fin_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], fin_at_end && (i == s.len() - 1));
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm_phase && ($urandom_range(99) < 10);
  end

  always @(posedge clk) begin
    token_beat_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_token_kind, out_start_offset, out_lexeme_length, out_start_line,
              out_start_column, out_error_code, out_end_of_run};
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token beat, actual %p", $time, got);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          $display("%0t: token mismatch, expected %p, actual %p", $time, want, got);
          fail_count++;
        end
      end
    end
  end

  task automatic drain_tokens();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk);
  endtask

  task automatic test_operators();
    send_text("(){},.-+;*/!!====>>=<<=", 1'b1);
    send_text("a/b//note\n=", 1'b1);
    send_text("!", 1'b1);
  endtask

  task automatic test_literals();
    send_text("12.5 7. 3.x 42", 1'b1);
    send_text("\"ab\ncd\" \"open\nstr", 1'b1);
    send_text("9.", 1'b1);
  endtask

  task automatic test_keywords();
    send_text("and class else false fun for if nil or super true var while", 1'b0);
    send_text(" whiles _x9 Zq", 1'b1);
  endtask

  task automatic test_errors();
    send_byte(8'hFF, 1'b0);
    send_text("ab\n@", 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_random_sources();
    string frags[$];
    string pick;
    int n;
    bit drained;
    frags = '{"var", "x", " ", "=", "12.75", "\n", "\"s t\"", "while", "(", ")",
              "<=", "!=", "//c\n", "foo_1", "{", "}", ";", "3.", ".", "super", "-"};
    n = 0;
    drained = 1'b0;
    while (n < 230) begin
      calm_phase = (n >= 100 && n < 160);
      if (!drained && n >= 190) begin
        drain_tokens();
        drained = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
        n++;
      end else begin
        pick = frags[$urandom_range(frags.size() - 1)];
        for (int i = 0; i < pick.len(); i++) begin
          send_byte(pick[i], $urandom_range(29) == 0);
          n++;
        end
      end
    end
    calm_phase = 1'b0;
    send_byte(" ", 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_byte = 8'h0;
    in_final_byte = 1'b0;
    out_stall = 1'b0;
    calm_phase = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    lex_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_operators();
    test_literals();
    test_keywords();
    test_errors();
    test_random_sources();
    drain_tokens();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("** script_token_lexer: PASSED **");
    end else begin
      $display("** script_token_lexer: FAILED **");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= 200000);
    $display("%0t: timeout", $time);
    $display("** script_token_lexer: FAILED **");
    $finish;
  end

endmodule
